FILE: sv/alc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types and constants of the array list with read cursor: payload
// structs of both channels, operation codes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package alc_pkg;

	// default number of entries the list can hold
	localparam int CAPACITY_DEF = 64;

	// fixed payload widths
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	// operation codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIRST  = 2'd1,
		OP_NEXT   = 2'd2,
		OP_REMOVE = 2'd3
	} opcode_t;

	// request transaction payload
	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [DATA_W-1:0] insert_value;
	} req_t;

	// response transaction payload
	typedef struct packed {
		logic                     success;
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       entry_count;
	} rsp_t;

	// commands from controller to datapath
	typedef struct packed {
		logic res_init;   // load result flag, clear result value
		logic res_ok;     // result flag loaded by res_init
		logic res_take;   // result value from memory read data
		logic ins_write;  // append the request value
		logic first_rd;   // read entry 0, cursor to 0
		logic next_rd;    // read entry after cursor, advance cursor
		logic rem_start;  // read entry under cursor, set up the shift
		logic shift_step; // move one entry down
		logic rem_end;    // drop the count after a remove
		logic out_load;   // load the response register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic next_ok;
		logic remove_ok;
		logic shift_done;
	} sts_t;

endpackage
`default_nettype wire

FILE: sv/alc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alc_ctrl
// Sequencer of the array list: takes one request transaction at a time,
// steps the datapath through the operation and hands the result to the
// response register.
// ----------------------------------------------------------------------------
module alc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire logic [1:0]    opcode,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	input  wire alc_pkg::sts_t sts,
	output alc_pkg::cmd_t      cmd
);
	import alc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_REM_HEAD,
		ST_SHIFT,
		ST_WB
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	// new requests only between operations
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.res_init = 1'b1;
					unique case (opcode_t'(opcode))
						OP_INSERT: begin
							cmd.res_ok    = !sts.full;
							cmd.ins_write = !sts.full;
							state_d       = ST_WB;
						end
						OP_FIRST: begin
							cmd.res_ok   = !sts.empty;
							cmd.first_rd = !sts.empty;
							state_d      = sts.empty ? ST_WB : ST_READ;
						end
						OP_NEXT: begin
							cmd.res_ok  = sts.next_ok;
							cmd.next_rd = sts.next_ok;
							state_d     = sts.next_ok ? ST_READ : ST_WB;
						end
						OP_REMOVE: begin
							cmd.res_ok    = sts.remove_ok;
							cmd.rem_start = sts.remove_ok;
							state_d       = sts.remove_ok ? ST_REM_HEAD : ST_WB;
						end
						default: state_d = ST_WB;
					endcase
				end
			end
			ST_READ: begin
				cmd.res_take = 1'b1;
				state_d      = ST_WB;
			end
			ST_REM_HEAD: begin
				// removed entry arrives from the memory
				cmd.res_take = 1'b1;
				state_d      = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_done) begin
					cmd.rem_end = 1'b1;
					state_d     = ST_WB;
				end
			end
			ST_WB: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// a fresh response only comes out of write-back
	a_rsp_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_WB))
		else $error("response raised outside write-back");

	// a blocked response register holds the result back
	a_wb_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB && rsp_valid_q && rsp_stall) |=> (state_q == ST_WB))
		else $error("write-back overran a stalled response");

	// a read always finishes in write-back
	a_read_to_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_WB))
		else $error("read did not go to write-back");
`endif

endmodule
`default_nettype wire

FILE: sv/alc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alc_dp
// Datapath of the array list: entry memory with registered read, entry
// count, cursor, shift pointers for remove, result and response registers.
// ----------------------------------------------------------------------------
module alc_dp #(
	parameter int CAPACITY = alc_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire alc_pkg::req_t req,
	input  wire alc_pkg::cmd_t cmd,
	output alc_pkg::sts_t      sts,
	output alc_pkg::rsp_t      rsp
);
	import alc_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// entry memory
	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rdata_q;
	logic                     rd_en;
	logic [IW-1:0]            rd_addr;
	logic                     wr_en;
	logic [IW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;

	// cursor held as position plus one, zero for no position; count is the number of entries
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            cur1_q;
	logic [CW-1:0]            cur_m1;

	// remove shift pointers
	logic [CW-1:0]            rptr_q;
	logic [IW-1:0]            wptr_q;
	logic                     rd_vld_q;
	logic                     rd_more;

	// result and response
	logic                     res_ok_q;
	logic signed [DATA_W-1:0] res_val_q;
	logic [CW+COUNT_W-1:0]    cnt_ext;
	rsp_t                     rsp_q;

	assign cur_m1  = cur1_q - CW'(1);
	assign rd_more = (rptr_q < count_q);
	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};

	// status to the controller
	assign sts.full       = (count_q >= CW'(CAPACITY));
	assign sts.empty      = (count_q == '0);
	assign sts.next_ok    = (cur1_q < count_q);
	assign sts.remove_ok  = (cur1_q != '0) && (cur1_q <= count_q);
	assign sts.shift_done = !rd_vld_q && !rd_more;

	assign rsp = rsp_q;

	// memory port select
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = req.insert_value;
		if (cmd.ins_write) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IW-1:0];
		end
		if (cmd.first_rd) begin
			rd_en = 1'b1;
		end
		if (cmd.next_rd) begin
			rd_en   = 1'b1;
			rd_addr = cur1_q[IW-1:0];
		end
		if (cmd.rem_start) begin
			rd_en   = 1'b1;
			rd_addr = cur_m1[IW-1:0];
		end
		if (cmd.shift_step) begin
			if (rd_vld_q) begin
				wr_en   = 1'b1;
				wr_addr = wptr_q;
				wr_data = rdata_q;
			end
			if (rd_more) begin
				rd_en   = 1'b1;
				rd_addr = rptr_q[IW-1:0];
			end
		end
	end

	// memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// count, cursor and shift pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cur1_q   <= '0;
			rptr_q   <= '0;
			wptr_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.rem_end) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.first_rd) begin
				cur1_q <= CW'(1);
			end
			if (cmd.next_rd) begin
				cur1_q <= cur1_q + CW'(1);
			end
			if (cmd.rem_start) begin
				cur1_q   <= cur_m1;
				rptr_q   <= cur1_q;
				wptr_q   <= cur_m1[IW-1:0];
				rd_vld_q <= 1'b0;
			end
			// one entry read ahead, one written behind
			if (cmd.shift_step) begin
				if (rd_vld_q) begin
					wptr_q <= wptr_q + IW'(1);
				end
				if (rd_more) begin
					rptr_q <= rptr_q + CW'(1);
				end
				rd_vld_q <= rd_more;
			end
		end
	end

	// result and response registers
	always_ff @(posedge clk) begin
		if (cmd.res_init) begin
			res_ok_q  <= cmd.res_ok;
			res_val_q <= '0;
		end
		if (cmd.res_take) begin
			res_val_q <= rdata_q;
		end
		if (cmd.out_load) begin
			rsp_q.success     <= res_ok_q;
			rsp_q.read_value  <= res_val_q;
			rsp_q.entry_count <= cnt_ext[COUNT_W-1:0];
		end
	end

`ifndef SYNTHESIS
	// count stays within the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// cursor never points past the last entry
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur1_q <= count_q)
		else $error("cursor beyond stored entries");

	// with a read in flight the read pointer leads the write pointer by two
	a_shift_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> ((CW + 1)'(wptr_q) + (CW + 1)'(2) == (CW + 1)'(rptr_q)))
		else $error("shift pointers out of step");
`endif

endmodule
`default_nettype wire

FILE: sv/array_list_with_cursor.sv
`default_nettype none
// Sequence: insert and any failed operation go from idle to write-back and
// the response register, first and next pass through a read state, and
// remove reads the entry under the cursor, then runs a shift loop that moves
// one entry per cycle through a read port and a write port of the memory.
// Throughput: one request at a time; a new request is taken once its
// predecessor's result has been loaded into the response register.
// Reset: asynchronous; clears the count and the cursor, entries are not cleared.
// ----------------------------------------------------------------------------
// array_list_with_cursor
// Bounded list store with a read cursor: insert, first, next and remove at
// cursor, one response transaction per request transaction.
// ----------------------------------------------------------------------------
module array_list_with_cursor #(
	parameter int CAPACITY = alc_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire alc_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output alc_pkg::rsp_t      rsp
);
	import alc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	alc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (req.opcode),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and result path
	alc_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

FILE: dv/array_list_with_cursor_chk.sv
// ----------------------------------------------------------------------------
// array_list_with_cursor_chk
// Watches both channels of the list store. Every request transaction is
// applied to a private list model, and the response that the model predicts
// is queued. Each response transaction is compared, field by field, with the
// oldest queued prediction. Failures, the number of responses still due and
// a few usage counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module array_list_with_cursor_chk #(
	parameter int CAPACITY = alc_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_stall,
	input  wire alc_pkg::req_t req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire alc_pkg::rsp_t rsp,
	output int                 fail_count,
	output int                 outstanding,
	output int                 rsp_seen,
	output int                 full_rejects,
	output int                 removes_done
);
	import alc_pkg::*;

	// private copy of the list and its cursor
	logic signed [DATA_W-1:0] list_store [CAPACITY];
	int                       held_count = 0;
	int                       cursor_pos = -1;
	int                       fails = 0;
	int                       seen = 0;
	int                       refused = 0;
	int                       removed = 0;
	rsp_t                     due_q [$];

	// apply one request to the list model and build the response it must give
	function automatic rsp_t list_apply(req_t r);
		rsp_t res;
		res = '0;
		case (opcode_t'(r.opcode))
			OP_INSERT: begin
				if (held_count >= CAPACITY) begin
					refused++;
				end else begin
					list_store[held_count] = r.insert_value;
					held_count++;
					res.success = 1'b1;
				end
			end
			OP_FIRST: begin
				if (held_count > 0) begin
					cursor_pos = 0;
					res.success = 1'b1;
					res.read_value = list_store[0];
				end
			end
			OP_NEXT: begin
				if (cursor_pos + 1 < held_count) begin
					cursor_pos++;
					res.success = 1'b1;
					res.read_value = list_store[cursor_pos];
				end
			end
			OP_REMOVE: begin
				// nothing happens without a cursor on a stored entry
				if (cursor_pos >= 0 && cursor_pos < held_count) begin
					res.success = 1'b1;
					res.read_value = list_store[cursor_pos];
					for (int i = cursor_pos; i + 1 < held_count; i++)
						list_store[i] = list_store[i + 1];
					held_count--;
					cursor_pos--;
					removed++;
				end
			end
		endcase
		res.entry_count = held_count[COUNT_W-1:0];
		return res;
	endfunction

	// predict on every request transaction, check on every response transaction
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			held_count = 0;
			cursor_pos = -1;
			due_q.delete();
		end else begin
			if (req_valid && !req_stall)
				due_q.push_back(list_apply(req));
			if (rsp_valid && !rsp_stall) begin
				seen++;
				if (due_q.size() == 0) begin
					fails++;
					$display("%0t: response with none due: success %0b value %0d count %0d",
						$time, rsp.success, rsp.read_value, rsp.entry_count);
				end else begin
					want = due_q.pop_front();
					if (rsp.success !== want.success) begin
						fails++;
						$display("%0t: success expected %0b actual %0b",
							$time, want.success, rsp.success);
					end
					if (rsp.read_value !== want.read_value) begin
						fails++;
						$display("%0t: read_value expected %0d actual %0d",
							$time, want.read_value, rsp.read_value);
					end
					if (rsp.entry_count !== want.entry_count) begin
						fails++;
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, rsp.entry_count);
					end
				end
			end
		end
		fail_count   <= fails;
		outstanding  <= due_q.size();
		rsp_seen     <= seen;
		full_rejects <= refused;
		removes_done <= removed;
	end

endmodule

FILE: dv/array_list_with_cursor_tb.sv
// ----------------------------------------------------------------------------
// array_list_with_cursor_tb
// Drives the list store with a short directed run over the empty, end and
// no-cursor cases and the value extremes, then with phases of random
// requests shaped as fills, walks, drains and noise. Both sides idle
// in random bursts, and the response side once holds off for a long stretch
// so that the block backs up. Checking is done by the checker beside it.
// ----------------------------------------------------------------------------
module array_list_with_cursor_tb;
	import alc_pkg::*;

	localparam int ITEMS = 750;
	localparam int LONG_HOLD = 300;
	localparam logic [DATA_W-1:0] CORNER_VALUES [4] =
		'{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};

	typedef enum {MIX_FILL, MIX_WALK, MIX_DRAIN, MIX_NOISE} mix_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_item;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_item;

	int   fail_count;
	int   outstanding;
	int   rsp_seen;
	int   full_rejects;
	int   removes_done;
	int   items_sent = 0;
	bit   send_idle = 1'b0;
	bit   rsp_idle = 1'b0;
	bit   calm = 1'b0;
	bit   long_hold_done = 1'b0;

	array_list_with_cursor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_item)
	);

	array_list_with_cursor_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req_item),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp_item),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.rsp_seen     (rsp_seen),
		.full_rejects (full_rejects),
		.removes_done (removes_done)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one request transaction, maybe after a gap, and wait for it to be taken
	task automatic offer(input opcode_t op, input logic [DATA_W-1:0] v);
		int gap;
		gap = 0;
		if (send_idle && !calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= '{opcode: op, insert_value: v};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
	endtask

	// response side: random stall bursts and one long hold-off
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!long_hold_done && items_sent >= 150) begin
				long_hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rsp_idle && !calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// stimulus and verdict
	initial begin
		mix_t             mix;
		int               span;
		int               roll;
		opcode_t          op;
		logic [DATA_W-1:0] value;
		bit               first_phase;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_item  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, no cursor, value extremes, end of list
		offer(OP_FIRST, $urandom);
		offer(OP_NEXT, $urandom);
		offer(OP_REMOVE, $urandom);
		offer(OP_INSERT, 32'h7fff_ffff);
		offer(OP_INSERT, 32'h8000_0000);
		offer(OP_INSERT, 32'h0000_0000);
		offer(OP_INSERT, 32'hffff_ffff);
		offer(OP_FIRST, $urandom);
		offer(OP_NEXT, $urandom);
		offer(OP_NEXT, $urandom);
		offer(OP_NEXT, $urandom);
		offer(OP_NEXT, $urandom);
		offer(OP_REMOVE, $urandom);
		offer(OP_REMOVE, $urandom);
		offer(OP_NEXT, $urandom);
		offer(OP_FIRST, $urandom);
		offer(OP_REMOVE, $urandom);
		offer(OP_REMOVE, $urandom);
		offer(OP_NEXT, $urandom);
		offer(OP_REMOVE, $urandom);

		// random phases, the first one a fill phase of mostly inserts
		first_phase = 1'b1;
		while (items_sent < ITEMS) begin
			mix = first_phase ? MIX_FILL : mix_t'($urandom_range(0, 3));
			first_phase = 1'b0;
			span = (mix == MIX_FILL) ? $urandom_range(70, 90) : $urandom_range(30, 90);
			send_idle = ($urandom_range(0, 2) != 0);
			rsp_idle  = ($urandom_range(0, 2) != 0);
			for (int k = 0; k < span && items_sent < ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:  op = (roll < 90) ? OP_INSERT : opcode_t'($urandom_range(1, 3));
					MIX_WALK:  op = (roll < 10) ? OP_FIRST : (roll < 20) ? OP_INSERT : OP_NEXT;
					MIX_DRAIN: op = (roll < 45) ? OP_REMOVE : (roll < 90) ? OP_NEXT : OP_FIRST;
					default:   op = opcode_t'($urandom_range(0, 3));
				endcase
				if ($urandom_range(0, 7) == 0)
					value = CORNER_VALUES[$urandom_range(0, 3)];
				else
					value = $urandom;
				calm = (items_sent >= ITEMS - 60);
				offer(op, value);
			end
		end
		req_valid <= 1'b0;

		// drain, then allow for a full-length remove
		while (outstanding != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("covered %0d requests and %0d responses over fill, walk, drain and noise phases",
			items_sent, rsp_seen);
		$display("%0d inserts refused on a full list, %0d removes done, one long response hold-off",
			full_rejects, removes_done);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS array_list_with_cursor");
		else
			$display("FAIL array_list_with_cursor");
		$finish;
	end

	// overall time limit
	initial begin
		#4_000_000;
		$display("FAIL array_list_with_cursor");
		$finish;
	end

endmodule
